[design/grayscale_led_matrix_scanner_unit_assert.svh]
// assertion macros used by the scanner top level
// expects clk_i and rst_ni in the scope of each use
`ifndef GRAYSCALE_LED_MATRIX_SCANNER_UNIT_ASSERT_SVH
`define GRAYSCALE_LED_MATRIX_SCANNER_UNIT_ASSERT_SVH

// property must hold at every clock edge out of reset
`define GLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define GLMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/glms_pkg.sv]
// package for the grayscale led matrix scanner
// holds matrix constants, register indexes and the transfer payload types
package glms_pkg;

  localparam int unsigned Rows          = 7;
  localparam int unsigned Cols          = 5;
  localparam int unsigned Levels        = 4;
  localparam int unsigned TopPhase      = Levels - 2;
  localparam int unsigned TimerWidthDef = 16;

  localparam int unsigned RowW    = 3;
  localparam int unsigned ColW    = 3;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned RegW    = 16;
  localparam int unsigned RegIdxW = 2;

  localparam int unsigned DwellReset = 64;

  typedef enum logic [RegIdxW-1:0] {
    REG_DWELL0 = 2'd0,
    REG_DWELL1 = 2'd1,
    REG_DWELL2 = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [RowW-1:0]   pixel_row;
    logic [ColW-1:0]   pixel_col;
    logic [LevelW-1:0] pixel_level;
  } in_item_t;

  typedef struct packed {
    logic [Rows-1:0]   row_select;
    logic [Cols-1:0]   col_drive;
    logic [RowW-1:0]   scan_row;
    logic [PhaseW-1:0] scan_phase;
  } out_item_t;

endpackage

[design/glms_out_buf.sv]
// two-entry output buffer: result register plus skid register
// depends on glms_pkg for the result payload type
module glms_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  glms_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output glms_pkg::out_item_t out_data_o
);
  import glms_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_valid_q && out_stall_i) begin
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_data_d  = data_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = push_i;
      out_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/grayscale_led_matrix_scanner_unit.sv]
// top level of the grayscale led matrix scanner
// depends on glms_pkg, glms_out_buf and the assertion macro header
`include "grayscale_led_matrix_scanner_unit_assert.svh"

// Takes one item (tick or pixel write) per clock unless stalled and gives one result per item
// from the output register; frame store, scan counters and column compare update in the
// cycle the item is accepted. A two-entry output buffer lets input transfers continue
// while a result waits; stall rises only once both entries are full. Each row shows phases
// Levels-2 down to 0, each lasting its dwell register in ticks (zero counts as one).
module grayscale_led_matrix_scanner_unit #(
  parameter int unsigned TIMER_WIDTH = glms_pkg::TimerWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  glms_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output glms_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [glms_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [glms_pkg::RegW-1:0]    cfg_data_i
);
  import glms_pkg::*;

  logic [RegW-1:0] dwell0_q, dwell1_q, dwell2_q;

  logic [Rows-1:0][Cols-1:0][LevelW-1:0] frame_q, frame_d;
  logic [RowW-1:0]        row_q, row_d;
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] cnt_q, cnt_d;

  logic [TIMER_WIDTH-1:0] dwell_sel, dwell_eff, cnt_inc;
  logic                   accept, buf_full;
  out_item_t              result;
  logic [Rows-1:0]        sel_of_row;

  assign accept     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell0_q <= RegW'(DwellReset);
      dwell1_q <= RegW'(DwellReset);
      dwell2_q <= RegW'(DwellReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DWELL0: dwell0_q <= cfg_data_i;
        REG_DWELL1: dwell1_q <= cfg_data_i;
        REG_DWELL2: dwell2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_q)
      PhaseW'(0): dwell_sel = TIMER_WIDTH'(dwell0_q);
      PhaseW'(1): dwell_sel = TIMER_WIDTH'(dwell1_q);
      default:    dwell_sel = TIMER_WIDTH'(dwell2_q);
    endcase
    dwell_eff = (dwell_sel == '0) ? TIMER_WIDTH'(1) : dwell_sel;
    cnt_inc   = cnt_q + TIMER_WIDTH'(1);
  end

  // state update for one transfer
  always_comb begin
    frame_d = frame_q;
    row_d   = row_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (in_data_i.op == OP_WRITE) begin
        if (in_data_i.pixel_row < RowW'(Rows) && in_data_i.pixel_col < ColW'(Cols)) begin
          frame_d[in_data_i.pixel_row][in_data_i.pixel_col] = in_data_i.pixel_level;
        end
      end else if (cnt_inc >= dwell_eff) begin
        cnt_d = '0;
        if (phase_q == '0) begin
          phase_d = PhaseW'(TopPhase);
          row_d   = (row_q == RowW'(Rows - 1)) ? '0 : row_q + RowW'(1);
        end else begin
          phase_d = phase_q - PhaseW'(1);
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // drive as seen after the transfer
  always_comb begin
    result.row_select = Rows'(1) << row_d;
    for (int j = 0; j < Cols; j++) begin
      result.col_drive[j] = (frame_d[row_d][j] <= LevelW'(phase_d));
    end
    result.scan_row   = row_d;
    result.scan_phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '1;
      row_q   <= '0;
      phase_q <= PhaseW'(TopPhase);
      cnt_q   <= '0;
    end else begin
      frame_q <= frame_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  glms_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign sel_of_row = Rows'(1) << out_data_o.scan_row;

  `GLMS_ASSERT(a_row_range, row_q <= RowW'(Rows - 1), "scan row out of range")
  `GLMS_ASSERT_NEVER(a_phase_range, phase_q > PhaseW'(TopPhase), "scan phase out of range")
  `GLMS_ASSERT(a_sel_match, out_valid_o |-> (out_data_o.row_select == sel_of_row), "row select mismatch")

endmodule
